// ===== rtl/d2s_idx_pkg.sv =====
// ============================================================================
// d2s_idx_pkg
// Shared types and constants of the depth-to-space index map: item structs,
// register indexes, layout codes and the block-size reciprocal table.
// ============================================================================
package d2s_idx_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 11;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_SIZE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYOUT_MODE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_DEPTH   = 3'd4;

   localparam logic [1:0] LAYOUT_NHWC     = 2'd0;
   localparam logic [1:0] LAYOUT_NCHW_DCR = 2'd1;
   localparam logic [1:0] LAYOUT_NCHW_CRD = 2'd2;

   localparam logic [3:0]  RESET_BLOCK_SIZE  = 4'd2;
   localparam logic [1:0]  RESET_LAYOUT_MODE = LAYOUT_NHWC;
   localparam logic [10:0] RESET_OUT_HEIGHT  = 11'd2;
   localparam logic [10:0] RESET_OUT_WIDTH   = 11'd2;
   localparam logic [10:0] RESET_OUT_DEPTH   = 11'd1;

   // width at which both indices are masked for the final wrap
   localparam int WIDE_BITS = 48;

   // ceil(2^15 / n), exact quotient for any 11-bit dividend
   localparam int RECIP_SHIFT = 15;
   localparam logic [15:0] RECIP_TABLE [16] = '{
      16'd32768, 16'd32768, 16'd16384, 16'd10923,
      16'd8192,  16'd6554,  16'd5462,  16'd4682,
      16'd4096,  16'd3641,  16'd3277,  16'd2979,
      16'd2731,  16'd2521,  16'd2341,  16'd2185
   };

   typedef struct packed {
      logic [3:0] batch_index;
      logic [9:0] row;
      logic [9:0] col;
      logic [9:0] channel;
   } req_type;

   typedef struct packed {
      logic [33:0] dest_index;
      logic [33:0] source_index;
   } rsp_type;

endpackage

// ===== rtl/depth_to_space_index_map.sv =====
// ============================================================================
// depth_to_space_index_map
// Depth-to-space address generator: output coordinate in, destination and
// source flat indices out, for NHWC, NCHW/DCR and NCHW/CRD layouts.
// ============================================================================
// One item is accepted per cycle while req_stall is low and passes through
// an input register followed by seven arithmetic stages, each holding
// about one multiply-add (block-size split by a reciprocal table and the
// destination index chain, then the source index chain). Each stage
// moves on as soon as the next one is free, so bubbles close up under
// rsp_stall and req_stall only rises when all eight stages hold an item.
// Configuration writes are always taken (csr_ready is high) and must be
// made while no item is in flight. Indices wrap modulo 2^INDEX_BITS.
module depth_to_space_index_map #(
   parameter int INDEX_BITS = 34
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  d2s_idx_pkg::req_type                     req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output d2s_idx_pkg::rsp_type                     rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [d2s_idx_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [d2s_idx_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int LastStage = 7;
   localparam logic [d2s_idx_pkg::WIDE_BITS-1:0] IdxMask =
      (d2s_idx_pkg::WIDE_BITS'(1) << INDEX_BITS) - d2s_idx_pkg::WIDE_BITS'(1);

   // configuration registers
   logic [3:0]  block_ff;
   logic [1:0]  layout_ff;
   logic [10:0] height_ff;
   logic [10:0] width_ff;
   logic [10:0] depth_ff;
   logic [3:0]  bs_eff;
   logic        cf;
   logic        crd;

   // pipeline control
   logic [LastStage:0] valid_ff;
   logic [LastStage:0] valid_in;
   logic [LastStage:0] take;

   // stage 0
   d2s_idx_pkg::req_type it0_ff;
   logic [3:0]  bs0_ff;

   // stage 1
   logic [15:0] recip;
   logic [25:0] prod_h;
   logic [25:0] prod_w;
   logic [26:0] prod_oh;
   logic [26:0] prod_ow;
   logic [10:0] a_sel;
   logic [9:0]  x_sel;
   d2s_idx_pkg::req_type it1_ff;
   logic [3:0]  bs1_ff;
   logic [9:0]  qh1_ff, qh1_in;
   logic [9:0]  qw1_ff, qw1_in;
   logic [10:0] ih1_ff, ih1_in;
   logic [10:0] iw1_ff, iw1_in;
   logic [14:0] odbs1_ff, odbs1_in;
   logic [15:0] d1_ff, d1_in;

   // stage 2
   logic [13:0] rem_h;
   logic [13:0] rem_w;
   logic [10:0] b_sel;
   logic [9:0]  y_sel;
   d2s_idx_pkg::req_type it2_ff;
   logic [3:0]  bs2_ff;
   logic [9:0]  qh2_ff;
   logic [9:0]  qw2_ff;
   logic [3:0]  offh2_ff, offh2_in;
   logic [3:0]  offw2_ff, offw2_in;
   logic [10:0] ih2_ff;
   logic [10:0] iw2_ff;
   logic [18:0] id2_ff, id2_in;
   logic [26:0] d2_ff, d2_in;

   // stage 3
   logic [10:0] c_sel;
   logic [9:0]  z_sel;
   d2s_idx_pkg::req_type it3_ff;
   logic [3:0]  bs3_ff;
   logic [9:0]  qh3_ff;
   logic [9:0]  qw3_ff;
   logic [3:0]  offw3_ff;
   logic [10:0] ih3_ff;
   logic [10:0] iw3_ff;
   logic [18:0] id3_ff;
   logic [13:0] g3_ff, g3_in;
   logic [37:0] d3_ff, d3_in;

   // stage 4
   logic [24:0] ind_wide;
   logic [3:0]  b4_ff;
   logic [9:0]  qh4_ff;
   logic [9:0]  qw4_ff;
   logic [10:0] ih4_ff;
   logic [10:0] iw4_ff;
   logic [18:0] id4_ff;
   logic [18:0] ind4_ff, ind4_in;
   logic [37:0] d4_ff;

   // stage 5
   logic [18:0] sa_sel;
   logic [18:0] sx_sel;
   logic [23:0] s5_ff, s5_in;
   logic [9:0]  qh5_ff;
   logic [9:0]  qw5_ff;
   logic [10:0] ih5_ff;
   logic [10:0] iw5_ff;
   logic [18:0] id5_ff;
   logic [18:0] ind5_ff;
   logic [37:0] d5_ff;

   // stage 6
   logic [10:0] sb_sel;
   logic [9:0]  sy_sel;
   logic [34:0] s6_ff, s6_in;
   logic [9:0]  qw6_ff;
   logic [10:0] iw6_ff;
   logic [18:0] id6_ff;
   logic [18:0] ind6_ff;
   logic [37:0] d6_ff;

   // stage 7
   logic [18:0] sc_sel;
   logic [18:0] sz_sel;
   logic [53:0] s7_full;
   d2s_idx_pkg::rsp_type rsp7_ff, rsp7_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff  <= d2s_idx_pkg::RESET_BLOCK_SIZE;
         layout_ff <= d2s_idx_pkg::RESET_LAYOUT_MODE;
         height_ff <= d2s_idx_pkg::RESET_OUT_HEIGHT;
         width_ff  <= d2s_idx_pkg::RESET_OUT_WIDTH;
         depth_ff  <= d2s_idx_pkg::RESET_OUT_DEPTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            d2s_idx_pkg::CSR_BLOCK_SIZE:  block_ff  <= csr_wdata[3:0];
            d2s_idx_pkg::CSR_LAYOUT_MODE: layout_ff <= csr_wdata[1:0];
            d2s_idx_pkg::CSR_OUT_HEIGHT:  height_ff <= csr_wdata;
            d2s_idx_pkg::CSR_OUT_WIDTH:   width_ff  <= csr_wdata;
            d2s_idx_pkg::CSR_OUT_DEPTH:   depth_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign bs_eff = (block_ff == 4'd0) ? 4'd1 : block_ff;
   assign cf     = (layout_ff != d2s_idx_pkg::LAYOUT_NHWC);
   assign crd    = (layout_ff == d2s_idx_pkg::LAYOUT_NCHW_CRD);

   // pipeline flow
   always_comb begin
      take[LastStage] = !valid_ff[LastStage] || !rsp_stall;
      for (int k = LastStage - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
      valid_in[0] = take[0] ? req_valid : valid_ff[0];
      for (int k = 1; k <= LastStage; k++) begin
         valid_in[k] = take[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !take[0];
   assign rsp_valid = valid_ff[LastStage];
   assign rsp_data  = rsp7_ff;

   // stage 0: input register
   always_ff @(posedge clock) begin
      if (take[0]) begin
         it0_ff <= req_data;
         bs0_ff <= bs_eff;
      end
   end

   // stage 1: quotients by reciprocal, source dims, first destination step
   always_comb begin
      recip    = d2s_idx_pkg::RECIP_TABLE[bs0_ff];
      prod_h   = 26'(it0_ff.row) * 26'(recip);
      prod_w   = 26'(it0_ff.col) * 26'(recip);
      prod_oh  = 27'(height_ff) * 27'(recip);
      prod_ow  = 27'(width_ff) * 27'(recip);
      qh1_in   = 10'(prod_h >> d2s_idx_pkg::RECIP_SHIFT);
      qw1_in   = 10'(prod_w >> d2s_idx_pkg::RECIP_SHIFT);
      ih1_in   = 11'(prod_oh >> d2s_idx_pkg::RECIP_SHIFT);
      iw1_in   = 11'(prod_ow >> d2s_idx_pkg::RECIP_SHIFT);
      odbs1_in = 15'(depth_ff) * 15'(bs0_ff);
      a_sel    = cf ? depth_ff : height_ff;
      x_sel    = cf ? it0_ff.channel : it0_ff.row;
      d1_in    = 16'(it0_ff.batch_index) * 16'(a_sel) + 16'(x_sel);
   end

   always_ff @(posedge clock) begin
      if (take[1]) begin
         it1_ff   <= it0_ff;
         bs1_ff   <= bs0_ff;
         qh1_ff   <= qh1_in;
         qw1_ff   <= qw1_in;
         ih1_ff   <= ih1_in;
         iw1_ff   <= iw1_in;
         odbs1_ff <= odbs1_in;
         d1_ff    <= d1_in;
      end
   end

   // stage 2: offsets in block, input depth, second destination step
   always_comb begin
      rem_h    = 14'(it1_ff.row) - 14'(qh1_ff) * 14'(bs1_ff);
      rem_w    = 14'(it1_ff.col) - 14'(qw1_ff) * 14'(bs1_ff);
      offh2_in = rem_h[3:0];
      offw2_in = rem_w[3:0];
      id2_in   = 19'(odbs1_ff) * 19'(bs1_ff);
      b_sel    = cf ? height_ff : width_ff;
      y_sel    = cf ? it1_ff.row : it1_ff.col;
      d2_in    = 27'(d1_ff) * 27'(b_sel) + 27'(y_sel);
   end

   always_ff @(posedge clock) begin
      if (take[2]) begin
         it2_ff   <= it1_ff;
         bs2_ff   <= bs1_ff;
         qh2_ff   <= qh1_ff;
         qw2_ff   <= qw1_ff;
         offh2_ff <= offh2_in;
         offw2_ff <= offw2_in;
         ih2_ff   <= ih1_ff;
         iw2_ff   <= iw1_ff;
         id2_ff   <= id2_in;
         d2_ff    <= d2_in;
      end
   end

   // stage 3: channel group, last destination step
   always_comb begin
      if (crd) begin
         g3_in = 14'(it2_ff.channel) * 14'(bs2_ff) + 14'(offh2_ff);
      end else begin
         g3_in = 14'(offh2_ff) * 14'(bs2_ff) + 14'(offw2_ff);
      end
      c_sel = cf ? width_ff : depth_ff;
      z_sel = cf ? it2_ff.col : it2_ff.channel;
      d3_in = 38'(d2_ff) * 38'(c_sel) + 38'(z_sel);
   end

   always_ff @(posedge clock) begin
      if (take[3]) begin
         it3_ff   <= it2_ff;
         bs3_ff   <= bs2_ff;
         qh3_ff   <= qh2_ff;
         qw3_ff   <= qw2_ff;
         offw3_ff <= offw2_ff;
         ih3_ff   <= ih2_ff;
         iw3_ff   <= iw2_ff;
         id3_ff   <= id2_ff;
         g3_ff    <= g3_in;
         d3_ff    <= d3_in;
      end
   end

   // stage 4: input channel
   always_comb begin
      if (crd) begin
         ind_wide = 25'(g3_ff) * 25'(bs3_ff) + 25'(offw3_ff);
      end else begin
         ind_wide = 25'(g3_ff) * 25'(depth_ff) + 25'(it3_ff.channel);
      end
      ind4_in = 19'(ind_wide);
   end

   always_ff @(posedge clock) begin
      if (take[4]) begin
         b4_ff   <= it3_ff.batch_index;
         qh4_ff  <= qh3_ff;
         qw4_ff  <= qw3_ff;
         ih4_ff  <= ih3_ff;
         iw4_ff  <= iw3_ff;
         id4_ff  <= id3_ff;
         ind4_ff <= ind4_in;
         d4_ff   <= d3_ff;
      end
   end

   // stage 5: first source step
   always_comb begin
      sa_sel = cf ? id4_ff : 19'(ih4_ff);
      sx_sel = cf ? ind4_ff : 19'(qh4_ff);
      s5_in  = 24'(b4_ff) * 24'(sa_sel) + 24'(sx_sel);
   end

   always_ff @(posedge clock) begin
      if (take[5]) begin
         s5_ff   <= s5_in;
         qh5_ff  <= qh4_ff;
         qw5_ff  <= qw4_ff;
         ih5_ff  <= ih4_ff;
         iw5_ff  <= iw4_ff;
         id5_ff  <= id4_ff;
         ind5_ff <= ind4_ff;
         d5_ff   <= d4_ff;
      end
   end

   // stage 6: second source step
   always_comb begin
      sb_sel = cf ? ih5_ff : iw5_ff;
      sy_sel = cf ? qh5_ff : qw5_ff;
      s6_in  = 35'(s5_ff) * 35'(sb_sel) + 35'(sy_sel);
   end

   always_ff @(posedge clock) begin
      if (take[6]) begin
         s6_ff   <= s6_in;
         qw6_ff  <= qw5_ff;
         iw6_ff  <= iw5_ff;
         id6_ff  <= id5_ff;
         ind6_ff <= ind5_ff;
         d6_ff   <= d5_ff;
      end
   end

   // stage 7: last source step and index wrap
   always_comb begin
      sc_sel  = cf ? 19'(iw6_ff) : id6_ff;
      sz_sel  = cf ? 19'(qw6_ff) : ind6_ff;
      s7_full = 54'(s6_ff) * 54'(sc_sel) + 54'(sz_sel);
      rsp7_in.dest_index =
         34'(d2s_idx_pkg::WIDE_BITS'(d6_ff) & IdxMask);
      rsp7_in.source_index =
         34'(d2s_idx_pkg::WIDE_BITS'(s7_full) & IdxMask);
   end

   always_ff @(posedge clock) begin
      if (take[7]) begin
         rsp7_ff <= rsp7_in;
      end
   end

   // assertions
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (offh2_ff < bs2_ff) && (offw2_ff < bs2_ff))
      else $error("block offset not below block size");

   a_row_split: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |->
         (14'(qh2_ff) * 14'(bs2_ff) + 14'(offh2_ff)) == 14'(it2_ff.row))
      else $error("row quotient and offset do not rebuild row");

   a_col_split: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |->
         (14'(qw2_ff) * 14'(bs2_ff) + 14'(offw2_ff)) == 14'(it2_ff.col))
      else $error("column quotient and offset do not rebuild column");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with a free pipeline stage");

endmodule
